[design/tfn_pkg.sv]
// Package for the triangle face normal core: coordinate and result types and
// the fixed widths of the normal datapath. No dependencies.
package tfn_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int NORM_WIDTH  = 16;
  localparam int ONE_Q14     = 16384;

  // Wide coordinates are narrowed so the cross products stay within 64 bits.
  localparam int EDGE_SHIFT  = (COORD_WIDTH > 30) ? COORD_WIDTH - 30 : 0;
  localparam int EDGE_WIDTH  = COORD_WIDTH + 1 - EDGE_SHIFT;
  localparam int PROD_WIDTH  = 2 * EDGE_WIDTH;
  localparam int CROSS_WIDTH = 2 * EDGE_WIDTH + 1;
  localparam int MAG_WIDTH   = 2 * EDGE_WIDTH;
  localparam int LEAD_WIDTH  = $clog2(MAG_WIDTH);
  localparam int NMAG_WIDTH  = 30;
  localparam int NORM_TOP    = NMAG_WIDTH - 1;
  localparam int SQ_WIDTH    = 64;
  localparam int SQRT_STEPS  = 31;
  localparam int LEN_WIDTH   = NMAG_WIDTH + 1;
  localparam int DIV_STEPS   = 15;
  localparam int DIV_WIDTH   = 46;
  localparam int FRAC_Q      = 14;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [NORM_WIDTH-1:0]  norm_t;

  typedef struct packed {
    coord_t a_x, a_y, a_z;
    coord_t b_x, b_y, b_z;
    coord_t c_x, c_y, c_z;
  } tri_in_t;

  typedef struct packed {
    coord_t pos_x, pos_y, pos_z;
    norm_t  norm_x, norm_y, norm_z;
    logic   last_vertex;
  } vtx_out_t;

  typedef struct packed {
    logic [2:0][NMAG_WIDTH-1:0] mag;
    logic [2:0]                 neg;
    logic                       degen;
  } norm_side_t;

endpackage

[design/triangle_face_normal_core.sv]
// The first vertex result is registered at the end of the normal pipeline;
// vertices b and c follow back to back from hold registers. A new triangle
// is taken only while busy is low; busy rises after each accepted one, so the
// single result port sets the rate. The normal path is a 55-stage pipeline
// (one stage per square-root bit and per quotient bit). Synchronous reset
// clears the valid bits, busy and the result strobe; the receiver cannot stall.
// Top level of the triangle face normal core; depends on tfn_pkg.
module triangle_face_normal_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  tfn_pkg::tri_in_t item,
  output logic             result_valid,
  output tfn_pkg::vtx_out_t result
);
  import tfn_pkg::*;

  localparam int LAT = 9 + SQRT_STEPS + DIV_STEPS;
  localparam int SIDE_LEN = SQRT_STEPS + 3;
  localparam int CW1 = COORD_WIDTH + 1;

  logic       accept;
  logic [1:0] gap;

  assign accept = start && !busy;
  assign busy   = (gap != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      gap <= 2'd0;
    end else if (accept) begin
      gap <= 2'd2;
    end else if (gap != 2'd0) begin
      gap <= gap - 2'd1;
    end
  end

  // Valid bits and vertex delay line.
  logic [LAT-1:0] vpipe;
  tri_in_t        vtx_pipe [LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[LAT-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    vtx_pipe[0] <= item;
    for (int i = 1; i < LAT; i++) begin
      vtx_pipe[i] <= vtx_pipe[i-1];
    end
  end

  // Stage 1: edges.
  coord_t pa [3], pb [3], pc [3];
  logic signed [CW1-1:0] d1 [3], d2 [3];
  logic signed [EDGE_WIDTH-1:0] e1 [3], e2 [3];

  assign pa[0] = item.a_x; assign pa[1] = item.a_y; assign pa[2] = item.a_z;
  assign pb[0] = item.b_x; assign pb[1] = item.b_y; assign pb[2] = item.b_z;
  assign pc[0] = item.c_x; assign pc[1] = item.c_y; assign pc[2] = item.c_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d1[k] = CW1'(pb[k]) - CW1'(pa[k]);
      d2[k] = CW1'(pc[k]) - CW1'(pa[k]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      e1[k] <= EDGE_WIDTH'(d1[k] >>> EDGE_SHIFT);
      e2[k] <= EDGE_WIDTH'(d2[k] >>> EDGE_SHIFT);
    end
  end

  // Stage 2: the six partial products of the cross product.
  logic signed [PROD_WIDTH-1:0] pr [6];

  always_ff @(posedge clk) begin
    pr[0] <= e2[1] * e1[2];
    pr[1] <= e2[2] * e1[1];
    pr[2] <= e2[2] * e1[0];
    pr[3] <= e2[0] * e1[2];
    pr[4] <= e2[0] * e1[1];
    pr[5] <= e2[1] * e1[0];
  end

  // Stage 3: cross components split into sign and magnitude.
  logic signed [CROSS_WIDTH-1:0] nc [3];
  logic [CROSS_WIDTH-1:0]        nabs [3];
  logic [MAG_WIDTH-1:0]          mag3 [3];
  logic [2:0]                    neg3;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nc[k]   = CROSS_WIDTH'(pr[2*k]) - CROSS_WIDTH'(pr[2*k+1]);
      nabs[k] = nc[k][CROSS_WIDTH-1] ? CROSS_WIDTH'(-nc[k]) : CROSS_WIDTH'(nc[k]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      mag3[k] <= nabs[k][MAG_WIDTH-1:0];
      neg3[k] <= nc[k][CROSS_WIDTH-1];
    end
  end

  // Stage 4: the leading one of the OR of the magnitudes is that of the largest.
  logic [MAG_WIDTH-1:0]  orv;
  logic [LEAD_WIDTH-1:0] lead_c, lead4;
  logic [MAG_WIDTH-1:0]  mag4 [3];
  logic [2:0]            neg4;
  logic                  degen4;

  always_comb begin
    orv    = mag3[0] | mag3[1] | mag3[2];
    lead_c = '0;
    for (int i = 0; i < MAG_WIDTH; i++) begin
      if (orv[i]) begin
        lead_c = LEAD_WIDTH'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    lead4  <= lead_c;
    mag4   <= mag3;
    neg4   <= neg3;
    degen4 <= (orv == '0);
  end

  // Stage 5: common normalizing shift into [2^29, 2^30).
  norm_side_t           side_pipe [SIDE_LEN];
  norm_side_t           side5;
  logic [MAG_WIDTH-1:0] shifted [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (lead4 >= LEAD_WIDTH'(NORM_TOP)) begin
        shifted[k] = mag4[k] >> (lead4 - LEAD_WIDTH'(NORM_TOP));
      end else begin
        shifted[k] = mag4[k] << (LEAD_WIDTH'(NORM_TOP) - lead4);
      end
      side5.mag[k] = shifted[k][NMAG_WIDTH-1:0];
    end
    side5.neg   = neg4;
    side5.degen = degen4;
  end

  always_ff @(posedge clk) begin
    side_pipe[0] <= side5;
    for (int i = 1; i < SIDE_LEN; i++) begin
      side_pipe[i] <= side_pipe[i-1];
    end
  end

  // Stages 6 and 7: squares, then their sum.
  logic [2*NMAG_WIDTH-1:0] sqr [3];
  logic [SQ_WIDTH-1:0]     sum_sq;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      sqr[k] <= side_pipe[0].mag[k] * side_pipe[0].mag[k];
    end
    sum_sq <= SQ_WIDTH'(sqr[0]) + SQ_WIDTH'(sqr[1]) + SQ_WIDTH'(sqr[2]);
  end

  // Square root, one result bit per stage.
  logic [SQ_WIDTH-1:0] sx [SQRT_STEPS];
  logic [SQ_WIDTH-1:0] sr [SQRT_STEPS];
  logic [SQ_WIDTH-1:0] x_in [SQRT_STEPS];
  logic [SQ_WIDTH-1:0] r_in [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [SQ_WIDTH-1:0] bitv, trial;

    if (k == 0) begin : g_first
      assign x_in[k] = sum_sq;
      assign r_in[k] = '0;
    end else begin : g_next
      assign x_in[k] = sx[k-1];
      assign r_in[k] = sr[k-1];
    end

    assign bitv  = SQ_WIDTH'(1) << (2 * (SQRT_STEPS - 1 - k));
    assign trial = r_in[k] + bitv;

    always_ff @(posedge clk) begin
      if (x_in[k] >= trial) begin
        sx[k] <= x_in[k] - trial;
        sr[k] <= (r_in[k] >> 1) + bitv;
      end else begin
        sx[k] <= x_in[k];
        sr[k] <= r_in[k] >> 1;
      end
    end
  end

  // Numerators: magnitude in Q14 plus half the length, for rounding.
  logic [LEN_WIDTH-1:0] len_c;
  logic [DIV_WIDTH-1:0] num [3];
  logic [LEN_WIDTH-1:0] num_len;
  logic [2:0]           num_neg;
  logic                 num_degen;

  assign len_c = sr[SQRT_STEPS-1][LEN_WIDTH-1:0];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      num[k] <= (DIV_WIDTH'(side_pipe[SIDE_LEN-1].mag[k]) << FRAC_Q)
              + DIV_WIDTH'(len_c >> 1);
    end
    num_len   <= len_c;
    num_neg   <= side_pipe[SIDE_LEN-1].neg;
    num_degen <= side_pipe[SIDE_LEN-1].degen;
  end

  // Restoring division, one quotient bit per stage for all three components.
  logic [DIV_WIDTH-1:0] dv_r [DIV_STEPS][3];
  logic [DIV_STEPS-1:0] dv_q [DIV_STEPS][3];
  logic [LEN_WIDTH-1:0] dv_len [DIV_STEPS];
  logic [2:0]           dv_neg [DIV_STEPS];
  logic                 dv_degen [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [DIV_WIDTH-1:0] rin [3];
    logic [DIV_STEPS-1:0] qin [3];
    logic [LEN_WIDTH-1:0] lin;
    logic [2:0]           nin;
    logic                 din;
    logic [DIV_WIDTH-1:0] trial;

    if (j == 0) begin : g_first
      always_comb begin
        for (int k = 0; k < 3; k++) begin
          rin[k] = num[k];
          qin[k] = '0;
        end
      end
      assign lin = num_len;
      assign nin = num_neg;
      assign din = num_degen;
    end else begin : g_next
      always_comb begin
        for (int k = 0; k < 3; k++) begin
          rin[k] = dv_r[j-1][k];
          qin[k] = dv_q[j-1][k];
        end
      end
      assign lin = dv_len[j-1];
      assign nin = dv_neg[j-1];
      assign din = dv_degen[j-1];
    end

    assign trial = DIV_WIDTH'(lin) << (DIV_STEPS - 1 - j);

    always_ff @(posedge clk) begin
      for (int k = 0; k < 3; k++) begin
        if (rin[k] >= trial) begin
          dv_r[j][k] <= rin[k] - trial;
          dv_q[j][k] <= qin[k] | (DIV_STEPS'(1) << (DIV_STEPS - 1 - j));
        end else begin
          dv_r[j][k] <= rin[k];
          dv_q[j][k] <= qin[k];
        end
      end
      dv_len[j]   <= lin;
      dv_neg[j]   <= nin;
      dv_degen[j] <= din;
    end
  end

  // Final stage: clamp to one, apply the sign, zero a degenerate triangle.
  norm_t              nq [3];
  logic [NORM_WIDTH-1:0] qclamp [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (dv_q[DIV_STEPS-1][k] > DIV_STEPS'(ONE_Q14)) begin
        qclamp[k] = NORM_WIDTH'(ONE_Q14);
      end else begin
        qclamp[k] = NORM_WIDTH'(dv_q[DIV_STEPS-1][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (dv_degen[DIV_STEPS-1]) begin
        nq[k] <= '0;
      end else if (dv_neg[DIV_STEPS-1][k]) begin
        nq[k] <= norm_t'(-qclamp[k]);
      end else begin
        nq[k] <= norm_t'(qclamp[k]);
      end
    end
  end

  // Output serializer: vertex a at once, then b and c from the hold registers.
  tri_in_t    hold_vtx;
  norm_t      hold_n [3];
  logic [1:0] phase;
  tri_in_t    vend;

  assign vend = vtx_pipe[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      phase        <= 2'd0;
    end else if (vpipe[LAT-1]) begin
      result_valid       <= 1'b1;
      phase              <= 2'd1;
      hold_vtx           <= vend;
      hold_n             <= nq;
      result.pos_x       <= vend.a_x;
      result.pos_y       <= vend.a_y;
      result.pos_z       <= vend.a_z;
      result.norm_x      <= nq[0];
      result.norm_y      <= nq[1];
      result.norm_z      <= nq[2];
      result.last_vertex <= 1'b0;
    end else if (phase == 2'd1) begin
      result_valid       <= 1'b1;
      phase              <= 2'd2;
      result.pos_x       <= hold_vtx.b_x;
      result.pos_y       <= hold_vtx.b_y;
      result.pos_z       <= hold_vtx.b_z;
      result.norm_x      <= hold_n[0];
      result.norm_y      <= hold_n[1];
      result.norm_z      <= hold_n[2];
      result.last_vertex <= 1'b0;
    end else if (phase == 2'd2) begin
      result_valid       <= 1'b1;
      phase              <= 2'd0;
      result.pos_x       <= hold_vtx.c_x;
      result.pos_y       <= hold_vtx.c_y;
      result.pos_z       <= hold_vtx.c_z;
      result.norm_x      <= hold_n[0];
      result.norm_y      <= hold_n[1];
      result.norm_z      <= hold_n[2];
      result.last_vertex <= 1'b1;
    end else begin
      result_valid       <= 1'b0;
      result.last_vertex <= 1'b0;
    end
  end

endmodule

[design/tfn_checker.sv]
// Port-level checks for the triangle face normal core, bound to the top level.
// Depends on tfn_pkg and triangle_face_normal_core.
module tfn_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              result_valid,
  input tfn_pkg::vtx_out_t result
);
  import tfn_pkg::*;

  // After an accepted transaction busy must stay high, blocking further starts.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy ##1 busy)
    else $error("busy not held after an accepted transaction");

  // The last vertex closes a run of three consecutive results.
  a_last_run: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last_vertex |->
      $past(result_valid, 1) && $past(result_valid, 2) &&
      !$past(result.last_vertex, 1) && !$past(result.last_vertex, 2))
    else $error("last vertex without two preceding results");

  // A first, non-last result must be followed by two more, the second one last.
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last_vertex && !$past(result_valid, 1) |=>
      result_valid ##1 (result_valid && result.last_vertex))
    else $error("vertex run broken");

  // The normal never exceeds unit length per component.
  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      $signed(result.norm_x) <= ONE_Q14 && $signed(result.norm_x) >= -ONE_Q14 &&
      $signed(result.norm_y) <= ONE_Q14 && $signed(result.norm_y) >= -ONE_Q14 &&
      $signed(result.norm_z) <= ONE_Q14 && $signed(result.norm_z) >= -ONE_Q14)
    else $error("normal component out of range");

endmodule

bind triangle_face_normal_core tfn_checker u_tfn_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);
